### design/dts_pkg.sv
// Shared types and codes of the deadline timer set.
package dts_pkg;

   localparam logic [1:0] ACT_ADD     = 2'd0;
   localparam logic [1:0] ACT_REMOVE  = 2'd1;
   localparam logic [1:0] ACT_PROCESS = 2'd2;

   localparam logic [1:0] KIND_ADD_ACK    = 2'd0;
   localparam logic [1:0] KIND_REMOVE_ACK = 2'd1;
   localparam logic [1:0] KIND_FIRED      = 2'd2;
   localparam logic [1:0] KIND_WAIT       = 2'd3;

   localparam logic [1:0] STAT_OK        = 2'd0;
   localparam logic [1:0] STAT_FULL      = 2'd1;
   localparam logic [1:0] STAT_NOT_FOUND = 2'd2;

   localparam logic [30:0] ID_MAX   = 31'h7FFF_FFFF;
   localparam logic [30:0] ID_FIRST = 31'd1;
   localparam logic [48:0] WAIT_MAX = 49'h0_0000_7FFF_FFFF;
   localparam logic signed [31:0] WAIT_NONE = -32'sd1;

   typedef struct packed {
      logic [1:0]  action;
      logic [47:0] now_ms;
      logic [30:0] period_ms;
      logic        repeat_req;
      logic [30:0] target_id;
   } req_type;

   typedef struct packed {
      logic [1:0]         kind;
      logic [30:0]        timer_id;
      logic [1:0]         status;
      logic signed [31:0] wait_ms;
      logic               last;
   } rsp_type;

   typedef struct packed {
      logic [30:0] id;
      logic [48:0] deadline;
      logic [30:0] period;
      logic        repeat_flag;
   } slot_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ADD,
      ST_SCAN,
      ST_DRAIN,
      ST_DECIDE
   } state_type;

endpackage

### design/dts_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module dts_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### design/deadline_timer_set.sv
// Top level of the deadline timer set: a table of one-shot and periodic timers.
//
// Requests arrive on the req_ channel (valid/ready); each carries an action and
// the current time. Results leave on the rsp_ channel (valid/ready), the final
// result of each request marked by last. An unknown action gives no result.
// A remove reads the slot memory one entry a cycle to look for the id. For a
// process request, every firing needs a full pass over the slot memory to find
// the earliest deadline, and a last pass finds the wait until the next deadline.
// Only one request is worked on at a time; req_ready is high while idle, even
// when a result still waits in the output register. When the receiver stalls,
// the block holds its result and waits until the transfer completes.
// Reset (synchronous, active high) marks every slot free, sets the next id to
// one and empties the output register; no clearing pass is needed, as slot
// validity is held in flip-flops.
module deadline_timer_set #(
   parameter int TIMER_SLOTS = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  dts_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output dts_pkg::rsp_type rsp_data
);

   localparam int IW = $clog2(TIMER_SLOTS);
   localparam int SW = $bits(dts_pkg::slot_type);
   localparam logic [IW-1:0] LAST_IDX = IW'(TIMER_SLOTS - 1);

   dts_pkg::state_type state_ff, state_in;
   dts_pkg::req_type   req_ff, req_in;
   logic [TIMER_SLOTS-1:0] valid_ff, valid_in;
   logic [TIMER_SLOTS-1:0] fired_ff, fired_in;
   logic [30:0]        next_id_ff, next_id_in;
   logic [IW-1:0]      scan_idx_ff, scan_idx_in;
   logic               cmp_act_ff, cmp_act_in;
   logic [IW-1:0]      cmp_idx_ff, cmp_idx_in;
   logic               final_ff, final_in;
   logic               best_vld_ff, best_vld_in;
   logic [IW-1:0]      best_idx_ff, best_idx_in;
   dts_pkg::slot_type  best_rec_ff, best_rec_in;
   logic               found_ff, found_in;
   logic [IW-1:0]      found_idx_ff, found_idx_in;
   logic               rsp_valid_ff, rsp_valid_in;
   dts_pkg::rsp_type   rsp_data_ff, rsp_data_in;

   logic               ram_we;
   logic [IW-1:0]      ram_waddr;
   dts_pkg::slot_type  ram_wdata;
   logic [SW-1:0]      ram_rdata_raw;
   dts_pkg::slot_type  ram_rdata;

   logic               free_vld;
   logic [IW-1:0]      free_idx;
   logic               out_free;
   logic [48:0]        now_ext;
   logic [48:0]        diff;
   logic signed [31:0] wait_val;
   logic               eligible;

   dts_ram #(
      .WIDTH(SW),
      .DEPTH(TIMER_SLOTS)
   ) u_slot_ram (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(ram_waddr),
      .wr_data(ram_wdata),
      .rd_addr(scan_idx_ff),
      .rd_data(ram_rdata_raw)
   );

   assign ram_rdata = dts_pkg::slot_type'(ram_rdata_raw);

   // Lowest free slot, from the validity flip-flops.
   always_comb begin
      free_vld = 1'b0;
      free_idx = '0;
      for (int i = TIMER_SLOTS - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            free_vld = 1'b1;
            free_idx = IW'(i);
         end
      end
   end

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign now_ext  = {1'b0, req_ff.now_ms};
   assign diff     = best_rec_ff.deadline - now_ext;

   // Wait report value: saturated distance to the earliest deadline; -1 if no timer is held.
   always_comb begin
      if (!best_vld_ff) begin
         wait_val = dts_pkg::WAIT_NONE;
      end else if (best_rec_ff.deadline <= now_ext) begin
         wait_val = 32'sd0;
      end else if (diff > dts_pkg::WAIT_MAX) begin
         wait_val = $signed(dts_pkg::WAIT_MAX[31:0]);
      end else begin
         wait_val = $signed(diff[31:0]);
      end
   end

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      valid_in     = valid_ff;
      fired_in     = fired_ff;
      next_id_in   = next_id_ff;
      scan_idx_in  = scan_idx_ff;
      cmp_act_in   = 1'b0;
      cmp_idx_in   = scan_idx_ff;
      final_in     = final_ff;
      best_vld_in  = best_vld_ff;
      best_idx_in  = best_idx_ff;
      best_rec_in  = best_rec_ff;
      found_in     = found_ff;
      found_idx_in = found_idx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      ram_we       = 1'b0;
      ram_waddr    = best_idx_ff;
      ram_wdata    = best_rec_ff;
      eligible     = 1'b0;

      // Compare stage: looks at the entry read in the previous cycle.
      if (cmp_act_ff) begin
         if (req_ff.action == dts_pkg::ACT_REMOVE) begin
            if (valid_ff[cmp_idx_ff] && !found_ff &&
                ram_rdata.id == req_ff.target_id) begin
               found_in     = 1'b1;
               found_idx_in = cmp_idx_ff;
            end
         end else begin
            eligible = valid_ff[cmp_idx_ff] && (final_ff || !fired_ff[cmp_idx_ff]);
            if (eligible && (!best_vld_ff || ram_rdata.deadline < best_rec_ff.deadline)) begin
               best_vld_in = 1'b1;
               best_idx_in = cmp_idx_ff;
               best_rec_in = ram_rdata;
            end
         end
      end

      case (state_ff)
         dts_pkg::ST_IDLE: begin
            if (req_valid) begin
               req_in      = req_data;
               scan_idx_in = '0;
               best_vld_in = 1'b0;
               found_in    = 1'b0;
               final_in    = 1'b0;
               fired_in    = '0;
               case (req_data.action)
                  dts_pkg::ACT_ADD:     state_in = dts_pkg::ST_ADD;
                  dts_pkg::ACT_REMOVE:  state_in = dts_pkg::ST_SCAN;
                  dts_pkg::ACT_PROCESS: state_in = dts_pkg::ST_SCAN;
                  default:              state_in = dts_pkg::ST_IDLE;
               endcase
            end
         end
         dts_pkg::ST_ADD: begin
            if (out_free) begin
               rsp_valid_in          = 1'b1;
               rsp_data_in.kind      = dts_pkg::KIND_ADD_ACK;
               rsp_data_in.wait_ms   = 32'sd0;
               rsp_data_in.last      = 1'b1;
               if (free_vld) begin
                  ram_we                = 1'b1;
                  ram_waddr             = free_idx;
                  ram_wdata.id          = next_id_ff;
                  ram_wdata.deadline    = now_ext + {18'd0, req_ff.period_ms};
                  ram_wdata.period      = req_ff.period_ms;
                  ram_wdata.repeat_flag = req_ff.repeat_req;
                  valid_in[free_idx]    = 1'b1;
                  next_id_in            = (next_id_ff == dts_pkg::ID_MAX) ?
                                          dts_pkg::ID_FIRST : next_id_ff + 31'd1;
                  rsp_data_in.timer_id  = next_id_ff;
                  rsp_data_in.status    = dts_pkg::STAT_OK;
               end else begin
                  rsp_data_in.timer_id  = '0;
                  rsp_data_in.status    = dts_pkg::STAT_FULL;
               end
               state_in = dts_pkg::ST_IDLE;
            end
         end
         dts_pkg::ST_SCAN: begin
            cmp_act_in = 1'b1;
            if (scan_idx_ff == LAST_IDX) begin
               state_in = dts_pkg::ST_DRAIN;
            end else begin
               scan_idx_in = scan_idx_ff + 1'b1;
            end
         end
         dts_pkg::ST_DRAIN: begin
            state_in = dts_pkg::ST_DECIDE;
         end
         dts_pkg::ST_DECIDE: begin
            if (req_ff.action == dts_pkg::ACT_REMOVE) begin
               if (out_free) begin
                  if (found_ff) begin
                     valid_in[found_idx_ff] = 1'b0;
                  end
                  rsp_valid_in         = 1'b1;
                  rsp_data_in.kind     = dts_pkg::KIND_REMOVE_ACK;
                  rsp_data_in.timer_id = '0;
                  rsp_data_in.status   = found_ff ? dts_pkg::STAT_OK :
                                                    dts_pkg::STAT_NOT_FOUND;
                  rsp_data_in.wait_ms  = 32'sd0;
                  rsp_data_in.last     = 1'b1;
                  state_in             = dts_pkg::ST_IDLE;
               end
            end else if (final_ff) begin
               if (out_free) begin
                  rsp_valid_in         = 1'b1;
                  rsp_data_in.kind     = dts_pkg::KIND_WAIT;
                  rsp_data_in.timer_id = '0;
                  rsp_data_in.status   = dts_pkg::STAT_OK;
                  rsp_data_in.wait_ms  = wait_val;
                  rsp_data_in.last     = 1'b1;
                  state_in             = dts_pkg::ST_IDLE;
               end
            end else if (best_vld_ff && best_rec_ff.deadline <= now_ext) begin
               // The earliest unfired timer is due: report it and reschedule or free it.
               if (out_free) begin
                  rsp_valid_in          = 1'b1;
                  rsp_data_in.kind      = dts_pkg::KIND_FIRED;
                  rsp_data_in.timer_id  = best_rec_ff.id;
                  rsp_data_in.status    = dts_pkg::STAT_OK;
                  rsp_data_in.wait_ms   = 32'sd0;
                  rsp_data_in.last      = 1'b0;
                  fired_in[best_idx_ff] = 1'b1;
                  if (best_rec_ff.repeat_flag) begin
                     ram_we             = 1'b1;
                     ram_wdata.deadline = now_ext + {18'd0, best_rec_ff.period};
                  end else begin
                     valid_in[best_idx_ff] = 1'b0;
                  end
                  best_vld_in = 1'b0;
                  scan_idx_in = '0;
                  state_in    = dts_pkg::ST_SCAN;
               end
            end else begin
               // Nothing more is due: one last pass over every held timer.
               final_in    = 1'b1;
               best_vld_in = 1'b0;
               scan_idx_in = '0;
               state_in    = dts_pkg::ST_SCAN;
            end
         end
         default: begin
            state_in = dts_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dts_pkg::ST_IDLE;
         valid_ff     <= '0;
         fired_ff     <= '0;
         next_id_ff   <= dts_pkg::ID_FIRST;
         scan_idx_ff  <= '0;
         cmp_act_ff   <= 1'b0;
         final_ff     <= 1'b0;
         best_vld_ff  <= 1'b0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         fired_ff     <= fired_in;
         next_id_ff   <= next_id_in;
         scan_idx_ff  <= scan_idx_in;
         cmp_act_ff   <= cmp_act_in;
         final_ff     <= final_in;
         best_vld_ff  <= best_vld_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff       <= req_in;
      cmp_idx_ff   <= cmp_idx_in;
      best_idx_ff  <= best_idx_in;
      best_rec_ff  <= best_rec_in;
      found_idx_ff <= found_idx_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign req_ready = (state_ff == dts_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
